>>> src/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // magnitude of a word: -2^(W-1) still fits unsigned
  localparam int MAG_BITS = WORD_BITS;
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int DISC_BITS = 2 * WORD_BITS + 1;
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int NUM_BITS = WORD_BITS + 2;
  localparam int DEN_BITS = WORD_BITS + 1;
  localparam int QUO_BITS = NUM_BITS + FRAC_BITS;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LINEAR = 2'd1,
    KIND_QUAD   = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                  root_count;
    logic signed [WORD_BITS-1:0] first_real;
    logic signed [WORD_BITS-1:0] first_imag;
    logic signed [WORD_BITS-1:0] second_real;
    logic signed [WORD_BITS-1:0] second_imag;
    logic                        overflow;
  } out_word_t;

  typedef struct packed {
    kind_t               kind;
    logic                a_neg;
    logic                b_neg;
    logic                c_neg;
    logic [MAG_BITS-1:0] a_mag;
    logic [MAG_BITS-1:0] b_mag;
    logic [MAG_BITS-1:0] c_mag;
  } front_word_t;

  typedef struct packed {
    front_word_t fw;
    logic        d_neg;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  d_neg;
    logic  q1_neg;
    logic  q2_neg;
  } div_side_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] n1;
    logic [NUM_BITS-1:0] n2;
    logic [DEN_BITS-1:0] den;
  } div_in_t;

endpackage
`default_nettype wire

>>> src/quadratic_root_solver_unit.sv
`default_nettype none
// channel   direction  word                  handshake
// item      in         qrs_pkg::in_word_t    item_valid / item_stall
// result    out        qrs_pkg::out_word_t   result_valid / result_stall
//
// One equation enters per cycle unless item_stall is raised; from accept to result valid it passes:
// classify register, queue, products, discriminant, 33-stage square root,
// numerator setup, 50-stage divider pair, output register.
// Reset clears all valid bits and the queue pointers; payload is not reset.
// A held result stalls the whole back pipeline; the front keeps taking
// words until the 4-entry queue fills.
module quadratic_root_solver_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qrs_pkg::in_word_t  item,
  input  wire logic               item_valid,
  output logic                    item_stall,
  output qrs_pkg::out_word_t      result,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 empty;
  qrs_pkg::front_word_t push_word;
  qrs_pkg::front_word_t head;

  qrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .push       (push),
    .push_word  (push_word),
    .full       (full)
  );

  qrs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  qrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
`default_nettype wire

>>> src/qrs_front.sv
`default_nettype none
module qrs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qrs_pkg::in_word_t  item,
  input  wire logic               item_valid,
  output logic                    item_stall,
  output logic                    push,
  output qrs_pkg::front_word_t    push_word,
  input  wire logic               full
);

  logic                 fvalid;
  qrs_pkg::front_word_t fw;
  qrs_pkg::front_word_t fw_next;

  function automatic logic [qrs_pkg::MAG_BITS-1:0] mag_of(
    input logic [qrs_pkg::WORD_BITS-1:0] x
  );
    return x[qrs_pkg::WORD_BITS-1] ? (~x) + qrs_pkg::MAG_BITS'(1) : x;
  endfunction

  always_comb begin
    fw_next.a_neg = item.coef_a[qrs_pkg::WORD_BITS-1];
    fw_next.b_neg = item.coef_b[qrs_pkg::WORD_BITS-1];
    fw_next.c_neg = item.coef_c[qrs_pkg::WORD_BITS-1];
    fw_next.a_mag = mag_of(item.coef_a);
    fw_next.b_mag = mag_of(item.coef_b);
    fw_next.c_mag = mag_of(item.coef_c);
    if (item.coef_a != '0) begin
      fw_next.kind = qrs_pkg::KIND_QUAD;
    end else if (item.coef_b != '0) begin
      fw_next.kind = qrs_pkg::KIND_LINEAR;
    end else begin
      fw_next.kind = qrs_pkg::KIND_NONE;
    end
  end

  assign push       = fvalid && !full;
  assign item_stall = fvalid && full;
  assign push_word  = fw;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (!fvalid || !full) begin
      fvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      fw <= fw_next;
    end
  end

endmodule
`default_nettype wire

>>> src/qrs_fifo.sv
`default_nettype none
module qrs_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire qrs_pkg::front_word_t push_word,
  output logic                      full,
  input  wire logic                 pop,
  output qrs_pkg::front_word_t      head,
  output logic                      empty
);

  qrs_pkg::front_word_t             mem [qrs_pkg::FIFO_DEPTH];
  logic [qrs_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [qrs_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [qrs_pkg::FIFO_PTR_BITS:0]   count;

  assign full  = count == (qrs_pkg::FIFO_PTR_BITS + 1)'(qrs_pkg::FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule
`default_nettype wire

>>> src/qrs_sqrt.sv
`default_nettype none
// floor square root, one result bit per stage
module qrs_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qrs_pkg::DISC_BITS-1:0] rad,
  input  wire qrs_pkg::sq_side_t             in_side,
  output logic                               out_valid,
  output logic [qrs_pkg::ROOT_BITS-1:0]      root,
  output qrs_pkg::sq_side_t                  out_side
);

  localparam int N  = qrs_pkg::ROOT_BITS;
  localparam int RW = qrs_pkg::ROOT_BITS + 3;

  typedef struct packed {
    logic                          valid;
    qrs_pkg::sq_side_t             side;
    logic [RW-1:0]                 rem;
    logic [N-1:0]                  root;
    logic [qrs_pkg::RAD_BITS-1:0]  rad;
  } sq_stage_t;

  sq_stage_t st [N+1];

  assign st[0] = '{valid: in_valid, side: in_side, rem: '0, root: '0,
                   rad: qrs_pkg::RAD_BITS'(rad)};

  for (genvar i = 0; i < N; i++) begin : g_step
    sq_stage_t     nxt;
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      t     = {st[i].rem[RW-3:0], st[i].rad[qrs_pkg::RAD_BITS-1 -: 2]};
      trial = RW'({st[i].root, 2'b01});
      ge    = t >= trial;
      nxt.valid = st[i].valid;
      nxt.side  = st[i].side;
      nxt.rem   = ge ? t - trial : t;
      nxt.root  = {st[i].root[N-2:0], ge};
      nxt.rad   = st[i].rad << 2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = st[N].valid;
  assign root      = st[N].root;
  assign out_side  = st[N].side;

endmodule
`default_nettype wire

>>> src/qrs_div.sv
`default_nettype none
// two restoring dividers sharing one divisor, one quotient bit per stage
module qrs_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire qrs_pkg::div_in_t             din,
  input  wire qrs_pkg::div_side_t           in_side,
  output logic                              out_valid,
  output logic [qrs_pkg::QUO_BITS-1:0]      q1,
  output logic [qrs_pkg::QUO_BITS-1:0]      q2,
  output qrs_pkg::div_side_t                out_side
);

  localparam int N  = qrs_pkg::QUO_BITS;
  localparam int DW = qrs_pkg::DEN_BITS;

  typedef struct packed {
    logic               valid;
    qrs_pkg::div_side_t side;
    logic [DW-1:0]      den;
    logic [DW-1:0]      rem1;
    logic [DW-1:0]      rem2;
    logic [N-1:0]       nq1;
    logic [N-1:0]       nq2;
  } div_stage_t;

  div_stage_t st [N+1];

  assign st[0] = '{valid: in_valid, side: in_side, den: din.den, rem1: '0, rem2: '0,
                   nq1: N'(din.n1) << qrs_pkg::FRAC_BITS,
                   nq2: N'(din.n2) << qrs_pkg::FRAC_BITS};

  for (genvar i = 0; i < N; i++) begin : g_step
    div_stage_t  nxt;
    logic [DW:0] t1;
    logic [DW:0] t2;
    logic [DW:0] d1;
    logic [DW:0] d2;
    logic        ge1;
    logic        ge2;

    always_comb begin
      t1  = {st[i].rem1, st[i].nq1[N-1]};
      t2  = {st[i].rem2, st[i].nq2[N-1]};
      ge1 = t1 >= {1'b0, st[i].den};
      ge2 = t2 >= {1'b0, st[i].den};
      d1  = t1 - {1'b0, st[i].den};
      d2  = t2 - {1'b0, st[i].den};
      nxt.valid = st[i].valid;
      nxt.side  = st[i].side;
      nxt.den   = st[i].den;
      nxt.rem1  = ge1 ? d1[DW-1:0] : t1[DW-1:0];
      nxt.rem2  = ge2 ? d2[DW-1:0] : t2[DW-1:0];
      nxt.nq1   = {st[i].nq1[N-2:0], ge1};
      nxt.nq2   = {st[i].nq2[N-2:0], ge2};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = st[N].valid;
  assign q1        = st[N].nq1;
  assign q2        = st[N].nq2;
  assign out_side  = st[N].side;

endmodule
`default_nettype wire

>>> src/qrs_back.sv
`default_nettype none
module qrs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire qrs_pkg::front_word_t head,
  input  wire logic                 empty,
  output logic                      pop,
  output qrs_pkg::out_word_t        result,
  output logic                      result_valid,
  input  wire logic                 result_stall
);

  localparam int W = qrs_pkg::WORD_BITS;
  localparam int Q = qrs_pkg::QUO_BITS;
  localparam int NB = qrs_pkg::NUM_BITS;

  typedef struct packed {
    logic [W-1:0] val;
    logic         ovf;
  } sat_t;

  typedef struct packed {
    logic          neg;
    logic [NB-1:0] mag;
  } sv_t;

  function automatic sat_t sat(input logic [Q-1:0] q, input logic neg);
    logic [Q-1:0] lim;
    logic [W-1:0] mag;
    sat_t         r;
    lim   = (Q'(1) << (W - 1)) - Q'(!neg);
    r.ovf = q > lim;
    mag   = r.ovf ? lim[W-1:0] : q[W-1:0];
    r.val = neg ? (~mag) + W'(1) : mag;
    return r;
  endfunction

  function automatic sv_t sadd(input sv_t x, input sv_t y);
    sv_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  logic en;
  assign en  = !(result_valid && result_stall);
  assign pop = !empty && en;

  // products
  logic                              v1;
  qrs_pkg::front_word_t              fw1;
  logic [qrs_pkg::PROD_BITS-1:0]     b2;
  logic [qrs_pkg::PROD_BITS-1:0]     ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fw1 <= head;
      b2  <= head.b_mag * head.b_mag;
      ac  <= head.a_mag * head.c_mag;
    end
  end

  // discriminant as sign and magnitude
  logic                          v2;
  qrs_pkg::sq_side_t             side2;
  logic [qrs_pkg::DISC_BITS-1:0] dmag;
  logic [qrs_pkg::DISC_BITS:0]   b2x;
  logic [qrs_pkg::DISC_BITS:0]   p4;
  logic [qrs_pkg::DISC_BITS:0]   dsum;
  logic                          dneg_next;

  always_comb begin
    b2x = (qrs_pkg::DISC_BITS + 1)'(b2);
    p4  = (qrs_pkg::DISC_BITS + 1)'(ac) << 2;
    dneg_next = 1'b0;
    if (fw1.a_neg != fw1.c_neg) begin
      dsum = b2x + p4;
    end else if (b2x >= p4) begin
      dsum = b2x - p4;
    end else begin
      dsum = p4 - b2x;
      dneg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2.fw    <= fw1;
      side2.d_neg <= dneg_next;
      dmag        <= dsum[qrs_pkg::DISC_BITS-1:0];
    end
  end

  logic                          v_sq;
  logic [qrs_pkg::ROOT_BITS-1:0] s;
  qrs_pkg::sq_side_t             side_sq;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .rad       (dmag),
    .in_side   (side2),
    .out_valid (v_sq),
    .root      (s),
    .out_side  (side_sq)
  );

  // numerators and divisor
  logic               v3;
  qrs_pkg::div_in_t   din;
  qrs_pkg::div_side_t dside;
  qrs_pkg::div_in_t   din_next;
  qrs_pkg::div_side_t dside_next;
  sv_t                nb;
  sv_t                sp;
  sv_t                sn;
  sv_t                n1;
  sv_t                n2;

  always_comb begin
    nb = '{neg: !side_sq.fw.b_neg, mag: NB'(side_sq.fw.b_mag)};
    sp = '{neg: 1'b0, mag: NB'(s)};
    sn = '{neg: 1'b1, mag: NB'(s)};
    n1 = '0;
    n2 = '0;
    din_next.den     = {side_sq.fw.a_mag, 1'b0};
    dside_next.kind  = side_sq.fw.kind;
    dside_next.d_neg = side_sq.d_neg;
    case (side_sq.fw.kind)
      qrs_pkg::KIND_LINEAR: begin
        n1 = '{neg: !side_sq.fw.c_neg, mag: NB'(side_sq.fw.c_mag)};
        din_next.den = qrs_pkg::DEN_BITS'(side_sq.fw.b_mag);
      end
      qrs_pkg::KIND_QUAD: begin
        if (!side_sq.d_neg) begin
          n1 = sadd(nb, sp);
          n2 = sadd(nb, sn);
        end else begin
          n1 = nb;
          n2 = sp;
        end
      end
      default: begin
      end
    endcase
    din_next.n1 = n1.mag;
    din_next.n2 = n2.mag;
    if (side_sq.fw.kind == qrs_pkg::KIND_LINEAR) begin
      dside_next.q1_neg = n1.neg ^ side_sq.fw.b_neg;
    end else begin
      dside_next.q1_neg = n1.neg ^ side_sq.fw.a_neg;
    end
    dside_next.q2_neg = n2.neg ^ side_sq.fw.a_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      din   <= din_next;
      dside <= dside_next;
    end
  end

  logic               v_div;
  logic [Q-1:0]       q1;
  logic [Q-1:0]       q2;
  qrs_pkg::div_side_t side_div;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .din       (din),
    .in_side   (dside),
    .out_valid (v_div),
    .q1        (q1),
    .q2        (q2),
    .out_side  (side_div)
  );

  // saturate and place the roots
  qrs_pkg::out_word_t res_next;
  sat_t               r1;
  sat_t               r2;
  sat_t               r2n;

  always_comb begin
    r1  = sat(q1, side_div.q1_neg);
    r2  = sat(q2, side_div.q2_neg);
    r2n = sat(q2, !side_div.q2_neg);
    res_next = '0;
    res_next.root_count = side_div.kind;
    case (side_div.kind)
      qrs_pkg::KIND_LINEAR: begin
        res_next.first_real = r1.val;
        res_next.overflow   = r1.ovf;
      end
      qrs_pkg::KIND_QUAD: begin
        res_next.first_real = r1.val;
        if (!side_div.d_neg) begin
          res_next.second_real = r2.val;
          res_next.overflow    = r1.ovf | r2.ovf;
        end else begin
          res_next.second_real = r1.val;
          res_next.first_imag  = r2.val;
          res_next.second_imag = r2n.val;
          res_next.overflow    = r1.ovf | r2.ovf | r2n.ovf;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v_div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire
